/* src/mbct_pkg.sv */
// shared constants and types for the multi-board coincidence tracker
`timescale 1ns / 1ps

package mbct_pkg;

    // defaults for the top level parameters
    localparam int BOARDS_DEF    = 16;
    localparam int TIME_BITS_DEF = 48;

    // fixed field widths
    localparam int BOARD_W    = 4;
    localparam int OUT_TIME_W = 48;
    localparam int MASK_W     = 16;
    localparam int COUNT_W    = 5;
    localparam int NBRD_W     = 5;
    localparam int WINDOW_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int COUNT_MAX = 31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOARDS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW        = 2'd1;

    // configuration reset values
    localparam logic [NBRD_W-1:0]   BOARDS_IN_USE_RST = 5'd16;
    localparam logic [WINDOW_W-1:0] WINDOW_RST        = 32'd1000;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

    // control for the scan unit at the head of the chain
    typedef struct packed {
        logic pass1;
        logic pass2;
        logic first;
        logic in_use;
    } t_scan_ctrl;

endpackage

/* src/mbct_cell.sv */
// one timestamp cell of the rotating board chain
`timescale 1ns / 1ps

module mbct_cell import mbct_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctrl           i_ctrl,
    input  logic [TIME_BITS-1:0] i_load_time,
    input  logic [TIME_BITS-1:0] i_next_time,
    output logic [TIME_BITS-1:0] o_time
);

    logic [TIME_BITS-1:0] r_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // latest possible time
            r_time <= '1;
        end else if (i_ctrl.load) begin
            r_time <= i_load_time;
        end else if (i_ctrl.shift) begin
            r_time <= i_next_time;
        end
    end

    assign o_time = r_time;

endmodule

/* src/mbct_scan.sv */
// head-of-chain unit: min and second search, then coincidence pass
`timescale 1ns / 1ps

module mbct_scan import mbct_pkg::*; #(
    parameter int   BOARDS    = BOARDS_DEF,
    parameter int   TIME_BITS = TIME_BITS_DEF,
    localparam int  IDX_W     = (BOARDS > 1) ? $clog2(BOARDS) : 1
) (
    input  logic                 i_clk,
    input  t_scan_ctrl           i_ctrl,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [TIME_BITS-1:0] i_head_time,
    input  logic [WINDOW_W-1:0]  i_window,
    output logic [TIME_BITS-1:0] o_min_time,
    output logic [IDX_W-1:0]     o_min_idx,
    output logic [TIME_BITS-1:0] o_sec_time,
    output logic [IDX_W-1:0]     o_sec_idx,
    output logic                 o_sec_valid,
    output logic [MASK_W-1:0]    o_mask,
    output logic [COUNT_W-1:0]   o_count
);

    localparam int CMP_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

    logic [TIME_BITS-1:0] r_min, n_min;
    logic [IDX_W-1:0]     r_min_idx, n_min_idx;
    logic [TIME_BITS-1:0] r_sec, n_sec;
    logic [IDX_W-1:0]     r_sec_idx, n_sec_idx;
    logic                 r_sec_valid, n_sec_valid;
    logic [MASK_W-1:0]    r_mask, n_mask;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [TIME_BITS-1:0] diff;

    assign diff = i_head_time - r_min;

    always_comb begin
        n_min       = r_min;
        n_min_idx   = r_min_idx;
        n_sec       = r_sec;
        n_sec_idx   = r_sec_idx;
        n_sec_valid = r_sec_valid;
        n_mask      = r_mask;
        n_count     = r_count;

        if (i_ctrl.pass1) begin
            if (i_ctrl.first) begin
                n_min       = i_head_time;
                n_min_idx   = i_idx;
                n_sec_valid = 1'b0;
            end else if (i_ctrl.in_use) begin
                if (i_head_time < r_min) begin
                    // old minimum drops to second place
                    n_sec       = r_min;
                    n_sec_idx   = r_min_idx;
                    n_sec_valid = 1'b1;
                    n_min       = i_head_time;
                    n_min_idx   = i_idx;
                end else if (!r_sec_valid || i_head_time < r_sec) begin
                    n_sec       = i_head_time;
                    n_sec_idx   = i_idx;
                    n_sec_valid = 1'b1;
                end
            end
        end

        if (i_ctrl.pass2) begin
            if (i_ctrl.first) begin
                n_mask  = '0;
                n_count = '0;
            end
            if (i_ctrl.in_use && (CMP_W'(diff) < CMP_W'(i_window))) begin
                // boards above the mask width shift out to nothing
                n_mask = n_mask | (MASK_W'(1) << i_idx);
                if (n_count != COUNT_W'(COUNT_MAX)) begin
                    n_count = n_count + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_min       <= n_min;
        r_min_idx   <= n_min_idx;
        r_sec       <= n_sec;
        r_sec_idx   <= n_sec_idx;
        r_sec_valid <= n_sec_valid;
        r_mask      <= n_mask;
        r_count     <= n_count;
    end

    assign o_min_time  = r_min;
    assign o_min_idx   = r_min_idx;
    assign o_sec_time  = r_sec;
    assign o_sec_idx   = r_sec_idx;
    assign o_sec_valid = r_sec_valid;
    assign o_mask      = r_mask;
    assign o_count     = r_count;

endmodule

/* src/multi_board_coincidence_tracker_unit.sv */
// top level: board timestamp chain, scan sequencer, result register
// Multi-board coincidence tracker.
// Input channel (i_in_valid / o_in_stall): a request carries a board index and
// its new event timestamp. The timestamp is written into that board's cell at
// the accepting edge if the board is among the boards in use.
// The cells then rotate through the scan unit at the head of the chain twice,
// one board per cycle: the first lap finds the earliest and second earliest
// times, the second lap marks the boards within the window of the minimum.
// After the two laps the chain is back in board order.
// One request is in work at a time: the input stalls from the accepting edge
// until both laps are done and the result has moved into the output register.
// Output channel (o_out_valid / i_out_stall): the result sits in an output
// register; a new request is accepted while it waits. If the receiver still
// stalls when the next scan ends, that result waits in the scan unit and the
// input stays stalled.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready; index 0 is the
// number of boards in use, index 1 the window in ticks.
// Reset sets every board time to all ones, 16 boards in use, window 1000.
`timescale 1ns / 1ps

module multi_board_coincidence_tracker_unit import mbct_pkg::*; #(
    parameter int BOARDS    = BOARDS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BOARD_W-1:0]    i_board,
    input  logic [OUT_TIME_W-1:0] i_timestamp,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [OUT_TIME_W-1:0] o_min_time,
    output logic [BOARD_W-1:0]    o_min_board,
    output logic [OUT_TIME_W-1:0] o_second_time,
    output logic [BOARD_W-1:0]    o_second_board,
    output logic [MASK_W-1:0]     o_coincident_mask,
    output logic [COUNT_W-1:0]    o_coincident_count,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (BOARDS > 1) ? $clog2(BOARDS) : 1;
    localparam int N_W   = $clog2(BOARDS + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BOARDS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS1,
        ST_PASS2,
        ST_DONE
    } t_state;

    t_state                r_state;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_out_valid;
    logic [OUT_TIME_W-1:0] r_min_time;
    logic [BOARD_W-1:0]    r_min_board;
    logic [OUT_TIME_W-1:0] r_second_time;
    logic [BOARD_W-1:0]    r_second_board;
    logic [MASK_W-1:0]     r_mask;
    logic [COUNT_W-1:0]    r_count;

    logic [NBRD_W-1:0]     r_boards_in_use;
    logic [WINDOW_W-1:0]   r_window;

    logic                  in_accept;
    logic                  out_free;
    logic                  board_ok;
    logic [N_W-1:0]        nb_eff;
    logic [TIME_BITS-1:0]  load_time;
    logic                  scanning;
    t_scan_ctrl            scan_ctrl;
    t_cell_ctrl            cell_ctrl [BOARDS];
    logic [TIME_BITS-1:0]  cell_time [BOARDS];

    logic [TIME_BITS-1:0]  scan_min_time;
    logic [IDX_W-1:0]      scan_min_idx;
    logic [TIME_BITS-1:0]  scan_sec_time;
    logic [IDX_W-1:0]      scan_sec_idx;
    logic                  scan_sec_valid;
    logic [MASK_W-1:0]     scan_mask;
    logic [COUNT_W-1:0]    scan_count;

    logic [63:0]           min_wide;
    logic [63:0]           sec_wide;
    logic [63:0]           ts_wide;
    logic [7:0]            min_idx_wide;
    logic [7:0]            sec_idx_wide;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boards_in_use <= BOARDS_IN_USE_RST;
            r_window        <= WINDOW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_BOARDS_IN_USE: r_boards_in_use <= i_cfg_data[NBRD_W-1:0];
                REG_WINDOW:        r_window        <= i_cfg_data[WINDOW_W-1:0];
                default:           ;
            endcase
        end
    end

    // boards in use, clamped to 1..BOARDS
    always_comb begin
        if (r_boards_in_use == '0) begin
            nb_eff = N_W'(1);
        end else if (int'(r_boards_in_use) > BOARDS) begin
            nb_eff = N_W'(BOARDS);
        end else begin
            nb_eff = N_W'(r_boards_in_use);
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign board_ok   = (8'(i_board) < 8'(nb_eff));
    assign ts_wide    = 64'(i_timestamp);
    assign load_time  = ts_wide[TIME_BITS-1:0];
    assign scanning   = (r_state == ST_PASS1) || (r_state == ST_PASS2);

    assign scan_ctrl.pass1  = (r_state == ST_PASS1);
    assign scan_ctrl.pass2  = (r_state == ST_PASS2);
    assign scan_ctrl.first  = (r_idx == '0);
    assign scan_ctrl.in_use = (N_W'(r_idx) < nb_eff);

    // ring of cells, cell 0 at the head; a full lap restores board order
    for (genvar k = 0; k < BOARDS; k++) begin : g_cell
        assign cell_ctrl[k].shift = scanning;
        assign cell_ctrl[k].load  = in_accept && board_ok && (int'(i_board) == k);

        mbct_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (cell_ctrl[k]),
            .i_load_time (load_time),
            .i_next_time (cell_time[(k + 1) % BOARDS]),
            .o_time      (cell_time[k])
        );
    end

    mbct_scan #(
        .BOARDS    (BOARDS),
        .TIME_BITS (TIME_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_ctrl      (scan_ctrl),
        .i_idx       (r_idx),
        .i_head_time (cell_time[0]),
        .i_window    (r_window),
        .o_min_time  (scan_min_time),
        .o_min_idx   (scan_min_idx),
        .o_sec_time  (scan_sec_time),
        .o_sec_idx   (scan_sec_idx),
        .o_sec_valid (scan_sec_valid),
        .o_mask      (scan_mask),
        .o_count     (scan_count)
    );

    assign min_wide     = 64'(scan_min_time);
    assign sec_wide     = 64'(scan_sec_time);
    assign min_idx_wide = 8'(scan_min_idx);
    assign sec_idx_wide = 8'(scan_sec_idx);

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the done state refills the output register itself
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= ST_PASS1;
                        r_idx   <= '0;
                    end
                end
                ST_PASS1: begin
                    if (r_idx == IDX_LAST) begin
                        r_state <= ST_PASS2;
                        r_idx   <= '0;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_PASS2: begin
                    if (r_idx == IDX_LAST) begin
                        r_state <= ST_DONE;
                        r_idx   <= '0;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_min_time     <= min_wide[OUT_TIME_W-1:0];
                        r_min_board    <= min_idx_wide[BOARD_W-1:0];
                        r_second_time  <= scan_sec_valid ? sec_wide[OUT_TIME_W-1:0] : '1;
                        r_second_board <= scan_sec_valid ? sec_idx_wide[BOARD_W-1:0] : '0;
                        r_mask         <= scan_mask;
                        r_count        <= scan_count;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_min_time         = r_min_time;
    assign o_min_board        = r_min_board;
    assign o_second_time      = r_second_time;
    assign o_second_board     = r_second_board;
    assign o_coincident_mask  = r_mask;
    assign o_coincident_count = r_count;

    // an accepted request always starts the first lap
    a_accept_starts_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_PASS1))
        else $error("accepted request did not start the scan");

    // a fresh result only comes out of the finished scan
    a_result_from_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside the done state");

    // every marked board was also counted
    a_mask_within_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones(o_coincident_mask) <= int'(o_coincident_count)))
        else $error("coincidence mask has more boards than the count");

endmodule

/* tb/mbct_result_checker.sv */
// checker for the coincidence tracker: board time model, queue of predicted results, compare
`timescale 1ns / 1ps

module mbct_result_checker import mbct_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [BOARD_W-1:0]    i_board,
    input  logic [OUT_TIME_W-1:0] i_timestamp,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [OUT_TIME_W-1:0] i_min_time,
    input  logic [BOARD_W-1:0]    i_min_board,
    input  logic [OUT_TIME_W-1:0] i_second_time,
    input  logic [BOARD_W-1:0]    i_second_board,
    input  logic [MASK_W-1:0]     i_coincident_mask,
    input  logic [COUNT_W-1:0]    i_coincident_count,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [OUT_TIME_W-1:0] min_time;
        logic [BOARD_W-1:0]    min_board;
        logic [OUT_TIME_W-1:0] second_time;
        logic [BOARD_W-1:0]    second_board;
        logic [MASK_W-1:0]     mask;
        logic [COUNT_W-1:0]    count;
    } t_coinc_report;

    logic [OUT_TIME_W-1:0] board_times [BOARDS_DEF];
    logic [NBRD_W-1:0]     boards_cfg;
    logic [WINDOW_W-1:0]   window_cfg;
    t_coinc_report         awaited_reports [$];

    // replace one board's time if that board is in use, then search minima and the coincidence set
    function automatic t_coinc_report advance_board(input logic [BOARD_W-1:0] brd,
                                                    input logic [OUT_TIME_W-1:0] ts);
        t_coinc_report r;
        int n;
        int i;
        logic sec_found;
        logic [OUT_TIME_W-1:0] diff;
        n = (boards_cfg == 0) ? 1 : ((boards_cfg > BOARDS_DEF) ? BOARDS_DEF : boards_cfg);
        if (brd < n)
            board_times[brd] = ts;
        r = '0;
        sec_found = 1'b0;
        r.min_time = board_times[0];
        for (i = 1; i < n; i++) begin
            if (board_times[i] < r.min_time) begin
                r.second_time = r.min_time;
                r.second_board = r.min_board;
                sec_found = 1'b1;
                r.min_time = board_times[i];
                r.min_board = BOARD_W'(i);
            end else if (!sec_found || board_times[i] < r.second_time) begin
                r.second_time = board_times[i];
                r.second_board = BOARD_W'(i);
                sec_found = 1'b1;
            end
        end
        if (!sec_found) begin
            r.second_time = '1;
            r.second_board = '0;
        end
        for (i = 0; i < n; i++) begin
            diff = board_times[i] - r.min_time;
            if (diff < window_cfg) begin
                r.mask[i] = 1'b1;
                if (r.count < COUNT_MAX)
                    r.count = r.count + 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_coinc_report seen;
        t_coinc_report want;
        int i;
        if (!i_rst_n) begin
            for (i = 0; i < BOARDS_DEF; i++)
                board_times[i] = '1;
            boards_cfg = BOARDS_IN_USE_RST;
            window_cfg = WINDOW_RST;
            awaited_reports.delete();
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_min_time, i_min_board, i_second_time, i_second_board,
                         i_coincident_mask, i_coincident_count};
                if (awaited_reports.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result with none pending: %p", $realtime, seen);
                end else begin
                    want = awaited_reports.pop_front();
                    if (seen !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"%0t: mismatch exp/act min %h/%h brd %0d/%0d ",
                                      "second %h/%h brd %0d/%0d mask %h/%h count %0d/%0d"},
                                     $realtime, want.min_time, seen.min_time,
                                     want.min_board, seen.min_board,
                                     want.second_time, seen.second_time,
                                     want.second_board, seen.second_board,
                                     want.mask, seen.mask, want.count, seen.count);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_BOARDS_IN_USE)
                    boards_cfg = i_cfg_data[NBRD_W-1:0];
                else if (i_cfg_index == REG_WINDOW)
                    window_cfg = i_cfg_data[WINDOW_W-1:0];
            end
            if (i_in_valid && !i_in_stall)
                awaited_reports.insert(awaited_reports.size(),
                                       advance_board(i_board, i_timestamp));
            o_pending = awaited_reports.size();
        end
    end

endmodule

/* tb/multi_board_coincidence_tracker_unit_tb.sv */
// top of the coincidence tracker testbench: clock, reset, request traffic and verdict
`timescale 1ns / 1ps

module multi_board_coincidence_tracker_unit_tb import mbct_pkg::*;;

    localparam int ITEMS_PER_PHASE = 123;
    localparam int PHASES          = 10;
    localparam int SETTLE_CYCLES   = 60;
    localparam int LIMIT_CYCLES    = 500000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [BOARD_W-1:0]    i_board;
    logic [OUT_TIME_W-1:0] i_timestamp;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [OUT_TIME_W-1:0] o_min_time;
    logic [BOARD_W-1:0]    o_min_board;
    logic [OUT_TIME_W-1:0] o_second_time;
    logic [BOARD_W-1:0]    o_second_board;
    logic [MASK_W-1:0]     o_coincident_mask;
    logic [COUNT_W-1:0]    o_coincident_count;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;

    // traffic shaping for the sender and the receiver
    logic        steady_send;
    logic        steady_recv;
    int          live_boards;
    logic [63:0] live_window;
    logic [OUT_TIME_W-1:0] time_base;

    multi_board_coincidence_tracker_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_board(i_board), .i_timestamp(i_timestamp),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_min_time(o_min_time), .o_min_board(o_min_board),
        .o_second_time(o_second_time), .o_second_board(o_second_board),
        .o_coincident_mask(o_coincident_mask), .o_coincident_count(o_coincident_count),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    mbct_result_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_board(i_board), .i_timestamp(i_timestamp),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_min_time(o_min_time), .i_min_board(o_min_board),
        .i_second_time(o_second_time), .i_second_board(o_second_board),
        .i_coincident_mask(o_coincident_mask), .i_coincident_count(o_coincident_count),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // one board event request, with a random gap ahead of it unless sending steadily
    task automatic send_event(input logic [BOARD_W-1:0] brd, input logic [OUT_TIME_W-1:0] ts);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_board <= brd;
        i_timestamp <= ts;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // hold requests back until every result is out and the scan has settled
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] boards_val,
                              input logic [CFG_DATA_W-1:0] window_val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_BOARDS_IN_USE;
        i_cfg_data <= boards_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= REG_WINDOW;
        i_cfg_data <= window_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        live_boards = (boards_val[NBRD_W-1:0] == 0) ? 1 :
                      ((boards_val[NBRD_W-1:0] > BOARDS_DEF) ? BOARDS_DEF :
                       int'(boards_val[NBRD_W-1:0]));
        live_window = {32'b0, window_val};
    endtask

    // mostly events clustered around an advancing base time, some wild ones
    task automatic random_event();
        logic [BOARD_W-1:0]    brd;
        logic [OUT_TIME_W-1:0] ts;
        logic [63:0]           span;
        int pick;
        pick = $urandom_range(0, 99);
        brd = (pick < 85) ? BOARD_W'($urandom_range(0, live_boards - 1))
                          : BOARD_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            time_base = time_base + $urandom_range(0, 300);
            span = (live_window < 64'd100000) ? 2 * live_window + 16
                                              : 64'd1 << $urandom_range(8, 40);
            ts = time_base + OUT_TIME_W'({$urandom, $urandom} % span);
        end else if (pick < 88) begin
            ts = OUT_TIME_W'({$urandom, $urandom});
        end else if (pick < 94) begin
            ts = '0;
        end else begin
            ts = '1;
        end
        send_event(brd, ts);
    endtask

    // receiver: a random stall ahead of every result, none in steady stretches
    initial begin
        int hold;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = steady_recv ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("multi_board_coincidence_tracker_unit_tb: FAIL");
        $finish;
    end

    initial begin
        logic [CFG_DATA_W-1:0] boards_val;
        logic [CFG_DATA_W-1:0] window_val;
        int phase;
        int k;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_board = '0;
        i_timestamp = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_BOARDS_IN_USE;
        i_cfg_data = '0;
        steady_send = 1'b0;
        steady_recv = 1'b0;
        live_boards = BOARDS_DEF;
        live_window = 64'd1000;
        time_base = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset configuration: extremes, ties and boards left at all ones
        send_event(4'd0, '0);
        send_event(4'd15, '1);
        send_event(4'd3, 48'd500);
        send_event(4'd7, 48'd999);
        send_event(4'd8, 48'd1000);
        send_event(4'd2, '0);
        send_event(4'd1, 48'hAAAA_AAAA_AAAA);
        send_event(4'd9, 48'h5555_5555_5555);
        wait_idle();
        // empty window: nothing coincides
        set_config(32'd16, 32'd0);
        send_event(4'd4, '0);
        wait_idle();
        // widest window, differences on either side of it
        set_config(32'd16, 32'hFFFF_FFFF);
        send_event(4'd5, 48'hFFFF_FFFE);
        send_event(4'd6, 48'h1_0000_0000);
        wait_idle();
        // single board, then a board that is not in use
        set_config(32'd1, 32'd1000);
        send_event(4'd0, 48'd123);
        send_event(4'd5, 48'd7);
        wait_idle();
        // a count of zero behaves as one board
        set_config(32'd0, 32'd50);
        send_event(4'd0, '1);
        send_event(4'd12, 48'd1);
        wait_idle();
        // counts above the board total are clamped
        set_config(32'd31, 32'd2000);
        send_event(4'd14, 48'd3);
        send_event(4'd0, 48'd3);
        wait_idle();
        set_config(32'd2, 32'd10);
        send_event(4'd1, 48'd3);
        send_event(4'd0, 48'd12);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin boards_val = 32'd16; window_val = 32'd0; end
                1: begin boards_val = 32'd1; window_val = 32'd1000; end
                2: begin boards_val = 32'd31; window_val = 32'hFFFF_FFFF; end
                3: begin boards_val = 32'd0; window_val = $urandom_range(0, 3000); end
                default: begin
                    boards_val = ($urandom_range(0, 2) == 0) ? $urandom
                                                             : $urandom_range(2, 16);
                    window_val = ($urandom_range(0, 2) == 0) ? $urandom
                                                             : $urandom_range(0, 5000);
                end
            endcase
            set_config(boards_val, window_val);
            steady_send = (phase % 4 == 1) || (phase % 4 == 3);
            steady_recv = (phase % 4 == 2) || (phase % 4 == 3);
            time_base = phase[0] ? OUT_TIME_W'({$urandom, $urandom})
                                 : OUT_TIME_W'($urandom_range(0, 5000));
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                random_event();
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("multi_board_coincidence_tracker_unit_tb: PASS");
        end else begin
            $display("multi_board_coincidence_tracker_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

/* multi_board_coincidence_tracker_unit.f */
src/mbct_pkg.sv
src/mbct_cell.sv
src/mbct_scan.sv
src/multi_board_coincidence_tracker_unit.sv
tb/mbct_result_checker.sv
tb/multi_board_coincidence_tracker_unit_tb.sv
